// File: sv/bloom_filter_double_hash_macros.svh
// assertion macros for the bloom filter checker
`ifndef BLOOM_FILTER_DOUBLE_HASH_MACROS_SVH
`define BLOOM_FILTER_DOUBLE_HASH_MACROS_SVH
`define BF_ASSERT_IMPL(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define BF_ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// File: sv/bfdh_pkg.sv
// shared types and constants for the bloom filter
`timescale 1ns / 1ps
`default_nettype none
package bfdh_pkg;
  localparam int MaxBits = 65536;
  localparam int AddrW = $clog2(MaxBits);
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic REG_NUM_BITS = 1'b0;
  localparam logic REG_NUM_HASHES = 1'b1;
  typedef struct packed {
    logic [1:0] op;
    logic [31:0] a;
    logic [31:0] b;
  } cmd_t;
endpackage
`default_nettype wire

// File: sv/bfdh_front.sv
// front end: accepts items, stores op and hash halves in a two-entry command queue
`timescale 1ns / 1ps
`default_nettype none
module bfdh_front (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [1:0] op,
  input wire logic [63:0] hash,
  output logic q_valid,
  input wire logic q_ready,
  output bfdh_pkg::cmd_t q_cmd
);
  import bfdh_pkg::*;
  cmd_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push, pop;
  assign in_ready = (cnt != 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_cmd = mem[rp];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= '{op: op, a: hash[31:0], b: hash[63:32]};
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: sv/bfdh_back.sv
// back end: probe sequencer, serial modulo unit, bit memory, clear sweep
`timescale 1ns / 1ps
`default_nettype none
module bfdh_back (
  input wire logic clk,
  input wire logic rst,
  input wire logic [16:0] num_bits,
  input wire logic [5:0] num_hashes,
  input wire logic q_valid,
  output logic q_ready,
  input wire bfdh_pkg::cmd_t q_cmd,
  output logic res_valid,
  input wire logic res_ready,
  output logic res_all_set,
  output logic [31:0] res_total
);
  import bfdh_pkg::*;
  localparam logic [2:0] S_SWEEP = 3'd0, S_IDLE = 3'd1, S_MOD = 3'd2,
                         S_RD = 3'd3, S_CHK = 3'd4, S_OUT = 3'd5;
  logic [2:0] state;
  logic mem [MaxBits];
  logic rd_bit;
  logic [AddrW-1:0] sweep;
  cmd_t cmd;
  logic [5:0] idx;
  logic [16:0] m;
  logic [31:0] val;
  logic [31:0] rem;
  logic [5:0] bcnt;
  logic [AddrW-1:0] addr;
  logic found_all;
  logic [31:0] count;
  logic [16:0] m_eff;
  logic [5:0] k_eff;
  logic [32:0] rem_sh;
  logic [32:0] trial;
  logic wr_en;
  logic [AddrW-1:0] wr_addr;
  logic wr_data;
  assign m_eff = (num_bits == 17'd0) ? 17'd1 :
                 (num_bits > 17'(MaxBits)) ? 17'(MaxBits) : num_bits;
  assign k_eff = (num_hashes > 6'd32) ? 6'd32 : num_hashes;
  assign q_ready = (state == S_IDLE) && !res_valid;
  // restoring divider step, one quotient bit a cycle
  assign rem_sh = {rem, val[31]};
  assign trial = rem_sh - {16'd0, m};
  always_comb begin
    wr_en = 1'b0;
    wr_addr = addr;
    wr_data = 1'b1;
    if (state == S_SWEEP) begin
      wr_en = 1'b1;
      wr_addr = sweep;
      wr_data = 1'b0;
    end else if (state == S_CHK && cmd.op == OP_INSERT) begin
      wr_en = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_bit <= mem[addr];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      sweep <= '0;
      res_valid <= 1'b0;
      count <= '0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_SWEEP: begin
          sweep <= sweep + 1'b1;
          if (sweep == AddrW'(MaxBits - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid && q_ready) begin
            cmd <= q_cmd;
            m <= m_eff;
            found_all <= 1'b1;
            if (q_cmd.op == OP_CLEAR) begin
              sweep <= '0;
              state <= S_SWEEP;
              res_all_set <= 1'b0;
              res_total <= count;
              res_valid <= 1'b1;
            end else if ((q_cmd.op == OP_INSERT || q_cmd.op == OP_QUERY)
                         && k_eff != 6'd0) begin
              idx <= k_eff - 6'd1;
              val <= q_cmd.a + (32'(k_eff - 6'd1) * q_cmd.b);
              rem <= '0;
              bcnt <= '0;
              state <= S_MOD;
            end else begin
              res_all_set <= (q_cmd.op == OP_INSERT || q_cmd.op == OP_QUERY);
              res_total <= count;
              res_valid <= 1'b1;
            end
          end
        end
        S_MOD: begin
          val <= {val[30:0], 1'b0};
          rem <= trial[32] ? rem_sh[31:0] : trial[31:0];
          bcnt <= bcnt + 6'd1;
          if (bcnt == 6'd31) begin
            addr <= trial[32] ? rem_sh[AddrW-1:0] : trial[AddrW-1:0];
            state <= S_RD;
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (!rd_bit) found_all <= 1'b0;
          if (idx == 6'd0 || (!rd_bit && cmd.op == OP_QUERY)) begin
            state <= S_OUT;
          end else begin
            idx <= idx - 6'd1;
            val <= cmd.a + (32'(idx - 6'd1) * cmd.b);
            rem <= '0;
            bcnt <= '0;
            state <= S_MOD;
          end
        end
        S_OUT: begin
          res_all_set <= found_all;
          if (cmd.op == OP_INSERT && !found_all && count != 32'hFFFF_FFFF) begin
            res_total <= count + 32'd1;
            count <= count + 32'd1;
          end else begin
            res_total <= count;
          end
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sv/bloom_filter_double_hash.sv
// top level of the double-hashing bloom filter
// each probe is a serial modulo, then a memory read, then a check
// an insert or query runs one probe per hash from accept to result; a query ends early on a clear bit
// a clear answers as it is taken, then the sweep over all MaxBits bits holds the back end
// one item at a time in the back end; a two-entry queue buffers the input side
// after rst the bit memory is swept to zero; num_bits 65536, num_hashes 7
`timescale 1ns / 1ps
`default_nettype none
module bloom_filter_double_hash (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input wire logic [71:0] s_axis_tdata, // op[1:0], hash[65:2], zero fill
  output logic m_axis_tvalid,
  input wire logic m_axis_tready,
  output logic [39:0] m_axis_tdata, // all_set[0], element_total[32:1], zero fill
  input wire logic cfg_we,
  input wire logic cfg_index,
  input wire logic [16:0] cfg_data
);
  import bfdh_pkg::*;
  logic [16:0] num_bits;
  logic [5:0] num_hashes;
  logic q_valid, q_ready;
  cmd_t q_cmd;
  logic all_set;
  logic [31:0] total;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_bits <= 17'd65536;
      num_hashes <= 6'd7;
    end else if (cfg_we) begin
      if (cfg_index == REG_NUM_BITS) num_bits <= cfg_data;
      if (cfg_index == REG_NUM_HASHES) num_hashes <= cfg_data[5:0];
    end
  end
  bfdh_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .op(s_axis_tdata[1:0]), .hash(s_axis_tdata[65:2]),
    .q_valid, .q_ready, .q_cmd
  );
  bfdh_back u_back (
    .clk, .rst, .num_bits, .num_hashes,
    .q_valid, .q_ready, .q_cmd,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_all_set(all_set), .res_total(total)
  );
  assign m_axis_tdata = {7'd0, total, all_set};
endmodule
`default_nettype wire

// File: sv/bfdh_checker.sv
// port-level checker for the bloom filter
`timescale 1ns / 1ps
`default_nettype none
`include "bloom_filter_double_hash_macros.svh"
module bfdh_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);
  logic stall, taken;
  logic [31:0] total;
  assign stall = m_axis_tvalid && !m_axis_tready;
  assign taken = m_axis_tvalid && m_axis_tready;
  assign total = m_axis_tdata[32:1];
  `BF_ASSERT_NEXT(a_out_hold, clk, rst, stall, m_axis_tvalid && $stable(m_axis_tdata), "result lost")
  `BF_ASSERT_IMPL(a_pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[39:33] == 7'd0, "fill not zero")
  `BF_ASSERT_NEXT(a_count_mono, clk, rst, taken, !m_axis_tvalid || total >= $past(total), "count down")
endmodule
bind bloom_filter_double_hash bfdh_checker u_checker (
  .clk, .rst, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

// File: sim/tb.sv
// testbench for the double-hashing bloom filter: random and directed stream traffic
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import bfdh_pkg::*;

  class filter_scoreboard;
    bit bits [0:65535];
    bit [31:0] elements;
    int unsigned modulus = 65536;
    int unsigned probes = 7;
    bit [32:0] answers [$];
    int mismatches = 0;

    function void clear_bits();
      foreach (bits[j]) bits[j] = 1'b0;
    endfunction

    // work out the response of one accepted transaction
    function void note_item(logic [1:0] op, logic [63:0] hash);
      bit [31:0] base, stride, sum, slot;
      int unsigned found;
      bit all;
      base = hash[31:0];
      stride = hash[63:32];
      found = 0;
      all = 1'b0;
      if (op == OP_INSERT) begin
        for (int i = probes - 1; i >= 0; i--) begin
          sum = base + i * stride;
          slot = sum % modulus;
          if (bits[slot]) found++;
          bits[slot] = 1'b1;
        end
        if (found == probes) all = 1'b1;
        else if (elements != 32'hFFFF_FFFF) elements++;
      end else if (op == OP_QUERY) begin
        all = 1'b1;
        for (int i = probes - 1; i >= 0; i--) begin
          sum = base + i * stride;
          slot = sum % modulus;
          if (!bits[slot]) all = 1'b0;
        end
      end else if (op == OP_CLEAR) begin
        clear_bits();
      end
      answers.push_back({elements, all});
    endfunction

    function void check_result(logic [39:0] data);
      bit [32:0] want;
      if (answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", data);
        return;
      end
      want = answers.pop_front();
      if (data[0] !== want[0] || data[32:1] !== want[32:1]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected all_set %0d total %0d, got all_set %0d total %0d",
                   want[0], want[32:1], data[0], data[32:1]);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [16:0] cfg_data = '0;

  filter_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit [63:0] inserted [$];

  bloom_filter_double_hash DUT (.*);

  always #5 clk = ~clk;

  // receiver: random stalls, and one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (3000) @(negedge clk);
        hold_req = 1'b0;
      end
      m_axis_tready = quiet ? 1'b1 : ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_item(logic [1:0] op, logic [63:0] hash);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {6'b0, hash, op};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(op, hash);
    if (op == OP_INSERT) inserted.push_back(hash);
    if (inserted.size() > 200) void'(inserted.pop_front());
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (!quiet && $urandom_range(99) < 10) @(negedge clk);
  endtask

  task automatic drain();
    while (sb.answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  // idle-only register write
  task automatic write_config(int unsigned nbits, int unsigned nhash);
    int unsigned wb, wh;
    drain();
    cfg_we = 1'b1;
    cfg_index = REG_NUM_BITS;
    cfg_data = nbits[16:0];
    @(negedge clk);
    cfg_index = REG_NUM_HASHES;
    cfg_data = nhash[16:0];
    @(negedge clk);
    cfg_we = 1'b0;
    wb = nbits & 32'h1FFFF;
    wh = nhash & 32'h3F;
    // zero bits acts as one, counts above the limits act as the limits
    if (wb == 0) wb = 1;
    if (wb > 65536) wb = 65536;
    if (wh > 32) wh = 32;
    sb.modulus = wb;
    sb.probes = wh;
  endtask

  task automatic random_phase(int count, int unsigned nbits, int unsigned nhash);
    logic [63:0] h;
    int pick;
    write_config(nbits, nhash);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 3 && nbits > 1000) begin
        h = {$urandom, $urandom};
        if (pick == 0) send_item(OP_CLEAR, h);
        else send_item(OP_QUERY, h);
      end else if (pick < 45) begin
        h = {$urandom, $urandom};
        if (pick < 10) h = {32'($urandom_range(3)), $urandom};
        send_item(OP_INSERT, h);
      end else if (pick < 80 && inserted.size() != 0) begin
        send_item(OP_QUERY, inserted[$urandom_range(inserted.size() - 1)]);
      end else begin
        send_item(OP_QUERY, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    sb.clear_bits();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    send_item(OP_INSERT, 64'h0);
    send_item(OP_QUERY, 64'h0);
    send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_QUERY, 64'h1234_5678_9ABC_DEF0);
    send_item(OP_INSERT, 64'h0);
    send_item(OP_CLEAR, 64'h0);
    send_item(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    // one-bit array: later probes of one insert see bits set by earlier ones
    write_config(1, 3);
    send_item(OP_INSERT, 64'h5555_5555_AAAA_AAAA);
    send_item(OP_INSERT, 64'h0000_0001_0000_0000);
    send_item(OP_QUERY, 64'h0);
    write_config(65536, 32);
    send_item(OP_INSERT, 64'h8000_0000_7FFF_FFFF);
    send_item(OP_QUERY, 64'h8000_0000_7FFF_FFFF);
    send_item(OP_QUERY, 64'h8000_0001_7FFF_FFFF);
    // shrink modulus, array kept
    write_config(64, 1);
    send_item(OP_QUERY, 64'h0);
    send_item(OP_INSERT, 64'h0000_0000_0000_0040);
    send_item(OP_CLEAR, 64'h0);
    send_item(OP_QUERY, 64'h0000_0000_0000_0040);

    random_phase(100, 65536, 7);
    // receiver hold-off while the sender keeps offering
    write_config(64, 3);
    hold_req = 1'b1;
    random_phase(80, 64, 3);
    quiet = 1'b1;
    random_phase(100, 1000, 5);
    quiet = 1'b0;
    random_phase(100, 1, 1);
    random_phase(60, 65536, 32);
    random_phase(100, 100, 2);
    random_phase(100, 37, 12);
    random_phase(60, 4096, 7);

    drain();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
